FILE: sv/critical_preserving_event_queue_macros.svh
// Assertion macros shared by the event queue modules.
`ifndef CRITICAL_PRESERVING_EVENT_QUEUE_MACROS_SVH
`define CRITICAL_PRESERVING_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CEPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CEPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cepq_pkg.sv
package cepq_pkg;

  // One stored event.
  typedef struct packed {
    logic        ctl;
    logic [7:0]  st;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [1:0]  len;
    logic [15:0] tag;
  } entry_t;

  // What a cell shows its neighbors: valid, own critical flag,
  // all-critical flag over itself and every cell above, and the entry.
  typedef struct packed {
    logic   v;
    logic   k;
    logic   s;
    entry_t ent;
  } link_t;

  // Broadcast operation of one cycle.
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_APPEND = 3'd1,
    OP_DEQ    = 3'd2,
    OP_EVICT  = 3'd3,
    OP_SWEEP  = 3'd4
  } op_t;

  typedef struct packed {
    op_t    op;
    logic   crit;
    entry_t ent;
  } cell_ctl_t;

  // Command codes.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Eviction codes.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_NEWEST = 2'd1;
  localparam logic [1:0] EV_OLDEST = 2'd2;

  // MIDI constants.
  localparam logic [7:0] ST_SYSTEM  = 8'hF0;
  localparam logic [3:0] HI_NOTEOFF = 4'h8;
  localparam logic [3:0] HI_NOTEON  = 4'h9;
  localparam logic [3:0] HI_CTRL    = 4'hB;
  localparam logic [7:0] CC_SUSTAIN = 8'd64;
  localparam logic [7:0] CC_SOUNDS  = 8'd120;
  localparam logic [7:0] CC_NOTES   = 8'd123;
  localparam logic [1:0] LEN_FULL   = 2'd3;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  eviction;
    logic        out_valid;
    entry_t      ent;
    logic [6:0]  fill;
    logic [31:0] drop;
  } result_t;

  function automatic logic is_crit(entry_t e);
    logic cc;
    logic r;
    cc = (e.d1 == CC_SUSTAIN) || (e.d1 == CC_SOUNDS) || (e.d1 == CC_NOTES);
    if (e.ctl) begin
      r = 1'b1;
    end else if (e.st >= ST_SYSTEM || e.len != LEN_FULL) begin
      r = 1'b0;
    end else begin
      r = (e.st[7:4] == HI_NOTEOFF) ||
          (e.st[7:4] == HI_NOTEON && e.d2 == 8'd0) ||
          (e.st[7:4] == HI_CTRL && e.d2 == 8'd0 && cc);
    end
    return r;
  endfunction

endpackage

FILE: sv/critical_preserving_event_queue.sv
// Channel   Dir  tdata (low bit up)                                       tuser
// s_axis    in   status[7:0] data_one[15:8] data_two[23:16]               command[0]
//                msg_length[25:24] event_tag[41:26] zero[47:42]           is_control[1]
// m_axis    out  accepted[0] eviction[2:1] out_valid[3] out_status[11:4]  out_is_control[0]
//                out_data_one[19:12] out_data_two[27:20] out_length[29:28]
//                out_tag[45:30] fill_level[52:46] drop_count[84:53] zero[87:85]
//
// Enqueue, dequeue and oldest-entry eviction update the cell row as the beat is taken.
// Evicting the newest non-critical entry starts a sweep in which the
// all-critical flags ripple down the cell row one cell per cycle; input is stalled.
// The result sits in an output register; a new beat is taken while it is being read.
// Reset (rst, synchronous) empties the queue and clears the drop counter.
module critical_preserving_event_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // status, data_one, data_two, msg_length, event_tag
  input  logic [1:0]  s_tuser,   // command, is_control
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // accepted, eviction, out_valid, out_status,
                                 // out_data_one, out_data_two, out_length, out_tag,
                                 // fill_level, drop_count
  output logic [0:0]  m_tuser    // out_is_control
);
  import cepq_pkg::*;

  entry_t    new_ent;
  cell_ctl_t cell_ctl;
  result_t   res;
  link_t     links [QUEUE_DEPTH+1];

  // Unpack the input beat.
  assign new_ent = '{ctl: s_tuser[1], st: s_tdata[7:0], d1: s_tdata[15:8],
                     d2: s_tdata[23:16], len: s_tdata[25:24], tag: s_tdata[41:26]};

  // Above the top cell: empty and all-critical.
  assign links[QUEUE_DEPTH] = '{v: 1'b0, k: 1'b1, s: 1'b1, ent: '0};

  cepq_ctrl #(.DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (s_tuser[0]),
    .new_ent  (new_ent),
    .head     (links[0]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .res      (res),
    .cell_ctl (cell_ctl)
  );

  // Row of cells, head at index zero.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic lower_v;
    if (i == 0) begin : g_head
      assign lower_v = 1'b1;
    end else begin : g_body
      assign lower_v = links[i-1].v;
    end
    cepq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (cell_ctl),
      .up      (links[i+1]),
      .lower_v (lower_v),
      .self    (links[i])
    );
  end

  // Pack the output beat.
  assign m_tdata = {3'b000, res.drop, res.fill, res.ent.tag, res.ent.len, res.ent.d2,
                    res.ent.d1, res.ent.st, res.out_valid, res.eviction, res.accepted};
  assign m_tuser = res.ent.ctl;
endmodule

FILE: sv/cepq_cell.sv
module cepq_cell (
  input  logic               clk,
  input  logic               rst,
  input  cepq_pkg::cell_ctl_t ctl,
  input  cepq_pkg::link_t    up,
  input  logic               lower_v,
  output cepq_pkg::link_t    self
);
  import cepq_pkg::*;

  logic   v;
  logic   k;
  logic   s;
  entry_t ent;

  // Control flags of the cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
      k <= 1'b1;
      s <= 1'b1;
    end else begin
      unique case (ctl.op)
        OP_APPEND: begin
          if (!v && lower_v) begin
            v <= 1'b1;
            k <= ctl.crit;
            s <= ctl.crit;
          end else if (v) begin
            s <= s & ctl.crit;
          end
        end
        OP_DEQ: begin
          v <= up.v;
          k <= up.k;
          s <= up.s;
        end
        OP_EVICT: begin
          // cells from the evicted one upward close up
          if (up.s) begin
            if (up.v) begin
              v <= up.v;
              k <= up.k;
              s <= up.s;
            end else begin
              v <= 1'b1;
              k <= ctl.crit;
              s <= ctl.crit;
            end
          end
        end
        OP_SWEEP: s <= (k | !v) & up.s;
        default: ;
      endcase
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_APPEND: if (!v && lower_v) ent <= ctl.ent;
      OP_DEQ:    ent <= up.ent;
      OP_EVICT: begin
        if (up.s) ent <= up.v ? up.ent : ctl.ent;
      end
      default: ;
    endcase
  end

  assign self = '{v: v, k: k, s: s, ent: ent};

`include "critical_preserving_event_queue_macros.svh"

  `CEPQ_ASSERT_NOW(a_thermo, v, lower_v, "valid cell above an empty cell")
  `CEPQ_ASSERT_NOW(a_empty_s, !v, s && up.s, "empty cell lost all-critical flag")
endmodule

FILE: sv/cepq_ctrl.sv
module cepq_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                cmd,
  input  cepq_pkg::entry_t    new_ent,
  input  cepq_pkg::link_t     head,
  input  logic                m_tready,
  output logic                m_tvalid,
  output cepq_pkg::result_t   res,
  output cepq_pkg::cell_ctl_t cell_ctl
);
  import cepq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SWEEP = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CW-1:0]    sweep_cnt;
  logic [CW-1:0]    sweep_cnt_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [31:0]      drop;
  logic [31:0]      drop_next;
  logic             take;
  logic             full;
  logic             new_crit;
  op_t              op;
  result_t          res_next;
  logic [CNT_W+6:0] count_wide;

  assign new_crit = is_crit(new_ent);
  assign full     = (count == CNT_W'(DEPTH));
  assign s_tready = (state == ST_RUN) && (!m_tvalid || m_tready);
  assign take     = s_tvalid && s_tready;

  // Pick the operation for the cell row.
  always_comb begin
    priority if (state == ST_SWEEP) op = OP_SWEEP;
    else if (!take) op = OP_HOLD;
    else if (cmd == CMD_DEQ) op = (count != '0) ? OP_DEQ : OP_HOLD;
    else if (!full) op = OP_APPEND;
    else if (!new_crit) op = OP_HOLD;
    else op = OP_EVICT;
  end

  assign cell_ctl = '{op: op, crit: new_crit, ent: new_ent};

  // Count and drop counter.
  always_comb begin
    count_next = count;
    drop_next  = drop;
    unique case (op)
      OP_APPEND: count_next = count + CNT_W'(1);
      OP_DEQ:    count_next = count - CNT_W'(1);
      default: ;
    endcase
    if (take && cmd == CMD_ENQ && full && !new_crit) drop_next = drop + 32'd1;
  end

  assign count_wide = {7'd0, count_next};

  // Result of the accepted beat.
  always_comb begin
    res_next      = '0;
    res_next.fill = count_wide[6:0];
    res_next.drop = drop_next;
    if (op == OP_APPEND || op == OP_EVICT) res_next.accepted = 1'b1;
    if (op == OP_EVICT) res_next.eviction = head.s ? EV_OLDEST : EV_NEWEST;
    if (op == OP_DEQ) begin
      res_next.out_valid = 1'b1;
      res_next.ent       = head.ent;
    end
  end

  // Sequencer: a newest-non-critical eviction rebuilds the flags below it.
  always_comb begin
    state_next     = state;
    sweep_cnt_next = sweep_cnt;
    unique case (state)
      ST_RUN: begin
        if (op == OP_EVICT && !head.s) begin
          state_next     = ST_SWEEP;
          sweep_cnt_next = CW'(DEPTH - 1);
        end
      end
      ST_SWEEP: begin
        sweep_cnt_next = sweep_cnt - CW'(1);
        if (sweep_cnt == CW'(1)) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      sweep_cnt <= '0;
      count     <= '0;
      drop      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      sweep_cnt <= sweep_cnt_next;
      count     <= count_next;
      drop      <= drop_next;
      if (take) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (take) res <= res_next;
  end

`include "critical_preserving_event_queue_macros.svh"

  `CEPQ_ASSERT_NOW(a_sweep_stall, state == ST_SWEEP, !s_tready, "beat taken during sweep")
  `CEPQ_ASSERT_NOW(a_count_max, 1'b1, count <= CNT_W'(DEPTH), "fill count past depth")
  `CEPQ_ASSERT_NEXT(a_evict_sweep, op == OP_EVICT && !head.s, state == ST_SWEEP,
                    "no sweep after newest non-critical eviction")
  `CEPQ_ASSERT_NEXT(a_deq_count, op == OP_DEQ, count + CNT_W'(1) == $past(count),
                    "dequeue did not lower count")
endmodule
